### hdl/tpcb_pkg.sv
// tpcb_pkg: shared constants, types, the neighbour scan function and the clamp
// of a written dimension for the transparent pixel colour bleed block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tpcb_pkg;

    // frame limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // field and counter widths
    localparam int PIX_W   = 32;
    localparam int CFG_W   = 11;
    localparam int CNT_W   = 21;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int IROW_W  = ROW_W + 1;
    localparam int DIM_W   = (COL_W > ROW_W ? COL_W : ROW_W) + 1;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int OUT_TDW = 56;

    // pixel masks
    localparam logic [PIX_W-1:0] ALPHA_MASK  = 32'hff00_0000;
    localparam logic [PIX_W-1:0] COLOUR_MASK = 32'h00ff_ffff;

    // register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // item kinds on the input tuser
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef logic [PIX_W-1:0] t_pixel;

    typedef struct packed {
        logic   ok;
        t_pixel found;
    } t_scan;

    // walk four neighbours in order, keep the first opaque one, flag a conflict
    function automatic t_scan scan4(input t_pixel q0, input t_pixel q1,
                                    input t_pixel q2, input t_pixel q3,
                                    input logic [3:0] inb, input t_pixel start);
        t_pixel q [4];
        t_scan  s;
        q[0] = q0;
        q[1] = q1;
        q[2] = q2;
        q[3] = q3;
        s.ok    = 1'b1;
        s.found = start;
        for (int k = 0; k < 4; k++) begin
            if (s.ok && inb[k] && ((q[k] & ALPHA_MASK) != '0)) begin
                if ((s.found != '0) && (q[k] != s.found)) begin
                    s.ok = 1'b0;
                end else begin
                    s.found = q[k];
                end
            end
        end
        return s;
    endfunction

    // clamp a written dimension into 1..limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] x;
        x = DIM_W'(v);
        if (x == '0) begin
            x = DIM_W'(1);
        end else if (x > lim) begin
            x = lim;
        end
        return x;
    endfunction

endpackage

`default_nettype wire

### hdl/transparent_pixel_colour_bleed.sv
// Transparent pixel colour bleed over a 3x3 window with two line memories.
// Pixel stream in, pixel stream out, APB register port.
// Depends on tpcb_pkg.
//
// Pixels enter in raster order and leave in the same order frame_width + 1
// beats later; after the last pixel of a frame, frame_width + 1 flush beats
// (or pixel beats, whose value is then dropped) push the tail out. A pixel
// with alpha zero takes the colour of its opaque in-bounds neighbours: up,
// left, right and down first, diagonals only when none of those is opaque;
// two opaque neighbours that differ leave it as it is. The block takes one
// beat per clock while the output is not stalled: each beat reads both line
// memories at its column in the cycle it is accepted and writes them back
// as it leaves stage 1, with a forwarding path when the next beat hits the
// same column. Results pass stages 1, 2 and the output register. Write the
// registers only while the block is idle; a write restarts the frame.
`timescale 1ns / 1ps
`default_nettype none

module transparent_pixel_colour_bleed (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input stream
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    input  wire logic [tpcb_pkg::PIX_W-1:0]      s_axis_tdata,  // [31:0] pixel_in
    input  wire logic                            s_axis_tuser,  // [0] mode
    // output stream
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output      logic [tpcb_pkg::OUT_TDW-1:0]    m_axis_tdata,  // [31:0] pixel_out,
                                                                // [52:32] change_count
    output      logic                            m_axis_tuser,  // [0] changed
    output      logic                            m_axis_tlast,  // last_of_frame
    // register port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tpcb_pkg::APB_AW-1:0]     paddr,
    input  wire logic [tpcb_pkg::APB_DW-1:0]     pwdata,
    output      logic [tpcb_pkg::APB_DW-1:0]     prdata,
    output      logic                            pready
);

    localparam int PW  = tpcb_pkg::PIX_W;
    localparam int CW  = tpcb_pkg::COL_W;
    localparam int RW  = tpcb_pkg::ROW_W;
    localparam int IRW = tpcb_pkg::IROW_W;
    localparam int DW  = tpcb_pkg::DIM_W;
    localparam int NW  = tpcb_pkg::CNT_W;

    // configuration registers
    logic [DW-1:0] r_width, r_height;
    logic          cfg_wr;

    // input side position state
    logic [CW-1:0]  r_in_col;
    logic [IRW-1:0] r_in_row;
    logic [CW-1:0]  r_out_col;
    logic [RW-1:0]  r_out_row;
    logic           r_finished;

    // stage 1: memory read data and beat info
    logic           r_s1_valid;
    logic [PW-1:0]  r_s1_v;
    logic [CW-1:0]  r_s1_col;
    logic           r_s1_emit, r_s1_last;
    logic [CW-1:0]  r_s1_ocol;
    logic [RW-1:0]  r_s1_orow;
    logic [PW-1:0]  r_up_q, r_mid_q;
    logic           r_fwd;
    logic [PW-1:0]  r_fwd_top, r_fwd_mid;

    // stage 2: window and beat info
    logic           r_s2_valid;
    logic           r_s2_emit, r_s2_last;
    logic [CW-1:0]  r_s2_ocol;
    logic [RW-1:0]  r_s2_orow;
    logic [PW-1:0]  r_win [9];
    logic [NW-1:0]  r_count;

    // output register
    logic           r_o_valid;
    logic [PW-1:0]  r_o_pix;
    logic           r_o_changed, r_o_last;
    logic [NW-1:0]  r_o_count;

    // line memories
    logic [PW-1:0]  mem_upper  [tpcb_pkg::MAX_WIDTH];
    logic [PW-1:0]  mem_middle [tpcb_pkg::MAX_WIDTH];

    // handshake and stage advance
    logic s2_adv, s1_adv, in_acc, load, active;
    logic [PW-1:0] in_v;
    logic emit0, last0;
    logic [PW-1:0] top_eff, mid_eff;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == tpcb_pkg::REG_FRAME_HEIGHT) ?
                    tpcb_pkg::APB_DW'(r_height) : tpcb_pkg::APB_DW'(r_width);

    assign s2_adv = r_s2_valid && (!r_s2_emit || !r_o_valid || m_axis_tready);
    assign s1_adv = r_s1_valid && (!r_s2_valid || s2_adv);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign active = r_finished || (s_axis_tuser == tpcb_pkg::MODE_PIXEL);
    assign load   = in_acc && active;
    assign in_v   = r_finished ? '0 : s_axis_tdata;

    // result slot and last-pixel detection at accept time
    assign emit0 = (r_in_row > IRW'(1)) || ((r_in_row == IRW'(1)) && (r_in_col != '0));
    assign last0 = emit0 && (DW'(r_out_row) == r_height - DW'(1))
                         && (DW'(r_out_col) == r_width - DW'(1));

    assign top_eff = r_fwd ? r_fwd_top : r_up_q;
    assign mid_eff = r_fwd ? r_fwd_mid : r_mid_q;

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DW'(tpcb_pkg::MAX_WIDTH);
            r_height <= DW'(tpcb_pkg::MAX_HEIGHT);
        end else if (cfg_wr) begin
            if (paddr[2] == tpcb_pkg::REG_FRAME_WIDTH) begin
                r_width <= tpcb_pkg::clamp_dim(pwdata[tpcb_pkg::CFG_W-1:0],
                                               DW'(tpcb_pkg::MAX_WIDTH));
            end else begin
                r_height <= tpcb_pkg::clamp_dim(pwdata[tpcb_pkg::CFG_W-1:0],
                                                DW'(tpcb_pkg::MAX_HEIGHT));
            end
        end
    end

    // input and output positions, frame restart on last pixel
    logic [CW-1:0]  n_in_col, n_out_col;
    logic [IRW-1:0] n_in_row;
    logic [RW-1:0]  n_out_row;
    logic           n_finished;

    always_comb begin
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_finished = r_finished;
        if (load) begin
            if (last0) begin
                n_in_col   = '0;
                n_in_row   = '0;
                n_out_col  = '0;
                n_out_row  = '0;
                n_finished = 1'b0;
            end else begin
                if (DW'(r_in_col) + DW'(1) >= r_width) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + IRW'(1);
                end else begin
                    n_in_col = r_in_col + CW'(1);
                end
                if ((DW'(r_in_row) == r_height - DW'(1))
                        && (DW'(r_in_col) == r_width - DW'(1))) begin
                    n_finished = 1'b1;
                end
                if (emit0) begin
                    if (DW'(r_out_col) + DW'(1) >= r_width) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + RW'(1);
                    end else begin
                        n_out_col = r_out_col + CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_finished <= 1'b0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_finished <= n_finished;
        end
    end

    // line memories: read at accept, write back when stage 1 moves on
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_up_q  <= mem_upper[r_in_col];
            r_mid_q <= mem_middle[r_in_col];
        end
        if (s1_adv) begin
            mem_upper[r_s1_col]  <= mid_eff;
            mem_middle[r_s1_col] <= r_s1_v;
        end
    end

    // stage 1 payload and same-column forwarding
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s1_v    <= in_v;
            r_s1_col  <= r_in_col;
            r_s1_emit <= emit0;
            r_s1_last <= last0;
            r_s1_ocol <= r_out_col;
            r_s1_orow <= r_out_row;
            r_fwd_top <= mid_eff;
            r_fwd_mid <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (load) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= s1_adv && (r_s1_col == r_in_col);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // stage 2: shift the window as a beat enters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_adv) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]   <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2] <= top_eff;
            r_win[5] <= mid_eff;
            r_win[8] <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_emit <= r_s1_emit;
            r_s2_last <= r_s1_last;
            r_s2_ocol <= r_s1_ocol;
            r_s2_orow <= r_s1_orow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_s2_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s2_valid <= 1'b1;
        end else if (s2_adv) begin
            r_s2_valid <= 1'b0;
        end
    end

    // neighbour bounds and bleed decision
    logic [3:0]    inb_o, inb_d;
    logic          ok_l, ok_r, ok_u, ok_d;
    tpcb_pkg::t_scan sc_o, sc_d, sc;
    logic [PW-1:0] centre, repl, res_pix;
    logic          res_chg;
    logic [NW-1:0] n_count;

    always_comb begin
        ok_l  = (r_s2_ocol != '0);
        ok_r  = (DW'(r_s2_ocol) + DW'(1) < r_width);
        ok_u  = (r_s2_orow != '0);
        ok_d  = (DW'(r_s2_orow) + DW'(1) < r_height);
        inb_o = {ok_d, ok_r, ok_l, ok_u};
        inb_d = {ok_d && ok_r, ok_d && ok_l, ok_u && ok_r, ok_u && ok_l};
        sc_o  = tpcb_pkg::scan4(r_win[1], r_win[3], r_win[5], r_win[7], inb_o, '0);
        sc_d  = tpcb_pkg::scan4(r_win[0], r_win[2], r_win[6], r_win[8], inb_d, '0);
        sc    = (sc_o.ok && (sc_o.found == '0)) ? sc_d : sc_o;
        centre  = r_win[4];
        repl    = sc.found & tpcb_pkg::COLOUR_MASK;
        res_chg = ((centre & tpcb_pkg::ALPHA_MASK) == '0) && sc.ok
                  && (sc.found != '0) && (repl != centre);
        res_pix = res_chg ? repl : centre;
        n_count = r_count + NW'(res_chg);
    end

    // per-frame change count, cleared after the last pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_count <= '0;
        end else if (s2_adv && r_s2_emit) begin
            r_count <= r_s2_last ? '0 : n_count;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (s2_adv && r_s2_emit) begin
            r_o_pix     <= res_pix;
            r_o_changed <= res_chg;
            r_o_last    <= r_s2_last;
            r_o_count   <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_o_valid <= 1'b0;
        end else if (s2_adv && r_s2_emit) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {{(tpcb_pkg::OUT_TDW - PW - NW){1'b0}}, r_o_count, r_o_pix};
    assign m_axis_tuser  = r_o_changed;
    assign m_axis_tlast  = r_o_last;

    // a replaced pixel always leaves with alpha zero
    a_changed_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_changed) |-> ((r_o_pix & tpcb_pkg::ALPHA_MASK) == '0))
        else $error("changed pixel with nonzero alpha");

    // a register write empties the pipeline
    a_cfg_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (!r_s1_valid && !r_s2_valid && !r_o_valid))
        else $error("pipeline not cleared by register write");

    // count restarts after the last pixel leaves stage 2
    a_count_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_adv && r_s2_emit && r_s2_last && !cfg_wr) |=> (r_count == '0))
        else $error("change count not cleared after last pixel");

    // positions stay inside the row
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (DW'(r_in_col) < r_width) && (DW'(r_out_col) < r_width))
        else $error("column position beyond frame width");

endmodule

`default_nettype wire
